// File: rtl/swdd_pkg.sv
// Shared constants and types for the sliding window distinct detector.
`timescale 1ns / 1ps

package swdd_pkg;

   // Field widths fixed by the interface
   localparam int SYM_W = 7;
   localparam int LEN_W = 4;
   localparam int CNT_W = 4;
   localparam int POS_W = 32;

   // ASCII code of the first letter of the alphabet
   localparam logic [SYM_W-1:0] FIRST_LETTER = 7'd97;

   // Window length after reset
   localparam logic [LEN_W-1:0] LEN_RESET = 4'd4;

   // Result queue depth and its index widths
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 3);

   // Control bits that travel with one beat down the pipeline
   typedef struct packed {
      logic valid;
      logic start;
      logic letter_ok;
      logic evict;
      logic full;
   } swdd_ctl_type;

   // One result beat
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] distinct;
   } swdd_result_type;

endpackage

// File: rtl/swdd_ram.sv
// Generic single-write, single-read synchronous RAM with registered, read-first output.
`timescale 1ns / 1ps

module swdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read old contents, then write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/swdd_window.sv
// Front stage: window length register, letter decode, ring of recent letters and position.
`timescale 1ns / 1ps

module swdd_window import swdd_pkg::*; #(
   parameter int MAX_WINDOW    = 14,
   parameter int ALPHABET_SIZE = 26
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [LEN_W-1:0]                 csr_wr_data,
   input  logic                             in_accept,
   input  logic [SYM_W-1:0]                 in_symbol,
   input  logic                             in_start,
   output swdd_ctl_type                     b_ctl,
   output logic [$clog2(ALPHABET_SIZE)-1:0] b_letter,
   output logic [$clog2(ALPHABET_SIZE)-1:0] b_evicted,
   output logic [LEN_W-1:0]                 b_len,
   output logic [POS_W-1:0]                 b_position
);

   localparam int LW = $clog2(ALPHABET_SIZE);
   localparam int RW = $clog2(MAX_WINDOW);

   logic [LEN_W-1:0] window_length_ff;
   logic [LEN_W-1:0] eff_len;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0] oldest_ff, oldest_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] base_fill, base_oldest, slot;
   logic [POS_W-1:0] base_pos;
   logic [SYM_W-1:0] sym_off;
   logic             letter_ok;
   logic [LW-1:0]    letter;
   logic             evict;
   logic             ring_wr_en;

   swdd_ctl_type     b_ctl_ff;
   logic [LW-1:0]    b_letter_ff;
   logic [LEN_W-1:0] b_len_ff;
   logic [POS_W-1:0] b_pos_ff;

   // Clamp the programmed length into the supported range
   always_comb begin
      if (window_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (32'(window_length_ff) > MAX_WINDOW) begin
         eff_len = LEN_W'(MAX_WINDOW);
      end else begin
         eff_len = window_length_ff;
      end
   end

   // Decode the symbol into a letter index
   assign sym_off   = in_symbol - FIRST_LETTER;
   assign letter_ok = (in_symbol >= FIRST_LETTER) && (32'(sym_off) < ALPHABET_SIZE);
   assign letter    = LW'(sym_off);

   // Pick the ring slot and advance fill, oldest slot and position
   always_comb begin
      base_fill   = in_start ? '0 : fill_ff;
      base_oldest = in_start ? '0 : oldest_ff;
      base_pos    = in_start ? '0 : pos_ff;
      fill_in     = base_fill;
      oldest_in   = base_oldest;
      pos_in      = base_pos;
      slot        = base_fill;
      evict       = 1'b0;
      if (letter_ok) begin
         if (base_fill < eff_len) begin
            slot    = base_fill;
            fill_in = base_fill + LEN_W'(1);
         end else begin
            slot  = base_oldest;
            evict = 1'b1;
            if (base_oldest + LEN_W'(1) >= eff_len) begin
               oldest_in = '0;
            end else begin
               oldest_in = base_oldest + LEN_W'(1);
            end
         end
         if (base_pos != '1) begin
            pos_in = base_pos + POS_W'(1);
         end
      end
   end

   // Hold window length; a write restarts the stream
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= LEN_RESET;
         fill_ff          <= '0;
         oldest_ff        <= '0;
         pos_ff           <= '0;
      end else if (csr_wr_en) begin
         window_length_ff <= csr_wr_data;
         fill_ff          <= '0;
         oldest_ff        <= '0;
         pos_ff           <= '0;
      end else if (in_accept) begin
         fill_ff   <= fill_in;
         oldest_ff <= oldest_in;
         pos_ff    <= pos_in;
      end
   end

   // Ring of recent letters; the read returns the letter being evicted
   assign ring_wr_en = in_accept & letter_ok;

   swdd_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (RW'(slot)),
      .wr_data (letter),
      .rd_addr (RW'(slot)),
      .rd_data (b_evicted)
   );

   // Advance the beat to the count stage
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff <= '0;
      end else begin
         b_ctl_ff.valid     <= in_accept;
         b_ctl_ff.start     <= in_start;
         b_ctl_ff.letter_ok <= letter_ok;
         b_ctl_ff.evict     <= evict;
         b_ctl_ff.full      <= (fill_in == eff_len);
      end
   end

   always_ff @(posedge clock) begin
      b_letter_ff <= letter;
      b_len_ff    <= eff_len;
      b_pos_ff    <= pos_in;
   end

   assign b_ctl      = b_ctl_ff;
   assign b_letter   = b_letter_ff;
   assign b_len      = b_len_ff;
   assign b_position = b_pos_ff;

endmodule

// File: rtl/swdd_tally.sv
// Count stage: per-letter add and remove counters in RAM, distinct total and marker flag.
`timescale 1ns / 1ps

module swdd_tally import swdd_pkg::*; #(
   parameter int ALPHABET_SIZE = 26
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  swdd_ctl_type                     b_ctl,
   input  logic [$clog2(ALPHABET_SIZE)-1:0] b_letter,
   input  logic [$clog2(ALPHABET_SIZE)-1:0] b_evicted,
   input  logic [LEN_W-1:0]                 b_len,
   input  logic [POS_W-1:0]                 b_position,
   output logic                             res_valid,
   output swdd_result_type                  res
);

   localparam int LW = $clog2(ALPHABET_SIZE);

   // Valid bits: an entry not written in this stream reads as zero
   logic [ALPHABET_SIZE-1:0] inc_vld_ff;
   logic [ALPHABET_SIZE-1:0] dec_vld_ff;

   swdd_ctl_type     c_ctl_ff;
   logic [LW-1:0]    c_letter_ff;
   logic [LW-1:0]    c_evicted_ff;
   logic [LEN_W-1:0] c_len_ff;
   logic [POS_W-1:0] c_pos_ff;
   logic             hit_il_ff, hit_ie_ff, hit_dl_ff, hit_de_ff;

   // Last cycle's writes, for forwarding
   logic             fi_vld_ff, fd_vld_ff;
   logic [LW-1:0]    fi_addr_ff, fd_addr_ff;
   logic [CNT_W-1:0] fi_data_ff, fd_data_ff;

   logic [CNT_W-1:0] distinct_ff;
   logic             found_ff;

   logic             clr_b;
   logic [CNT_W-1:0] inc_l_rd, inc_e_rd, dec_l_rd, dec_e_rd;
   logic [CNT_W-1:0] inc_l, inc_e, dec_l, dec_e;
   logic [CNT_W-1:0] cnt_l, cnt_e;
   logic [CNT_W-1:0] inc_wr_data, dec_wr_data;
   logic             inc_wr_en, dec_wr_en;
   logic [CNT_W-1:0] base_dist, dist_new;
   logic             base_found, found_now;

   // A start beat in this stage drops the older beat's writes and clears valid bits
   assign clr_b = b_ctl.valid & b_ctl.start;

   // Add counters, read at the new letter and at the evicted letter
   swdd_ram #(
      .WIDTH (CNT_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_inc_l (
      .clock   (clock),
      .wr_en   (inc_wr_en),
      .wr_addr (c_letter_ff),
      .wr_data (inc_wr_data),
      .rd_addr (b_letter),
      .rd_data (inc_l_rd)
   );

   swdd_ram #(
      .WIDTH (CNT_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_inc_e (
      .clock   (clock),
      .wr_en   (inc_wr_en),
      .wr_addr (c_letter_ff),
      .wr_data (inc_wr_data),
      .rd_addr (b_evicted),
      .rd_data (inc_e_rd)
   );

   // Remove counters, read at the same two letters
   swdd_ram #(
      .WIDTH (CNT_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_dec_l (
      .clock   (clock),
      .wr_en   (dec_wr_en),
      .wr_addr (c_evicted_ff),
      .wr_data (dec_wr_data),
      .rd_addr (b_letter),
      .rd_data (dec_l_rd)
   );

   swdd_ram #(
      .WIDTH (CNT_W),
      .DEPTH (ALPHABET_SIZE)
   ) u_dec_e (
      .clock   (clock),
      .wr_en   (dec_wr_en),
      .wr_addr (c_evicted_ff),
      .wr_data (dec_wr_data),
      .rd_addr (b_evicted),
      .rd_data (dec_e_rd)
   );

   // Advance the beat and sample valid bits alongside the reads
   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff <= '0;
      end else begin
         c_ctl_ff <= b_ctl;
      end
   end

   always_ff @(posedge clock) begin
      c_letter_ff  <= b_letter;
      c_evicted_ff <= b_evicted;
      c_len_ff     <= b_len;
      c_pos_ff     <= b_position;
      hit_il_ff    <= inc_vld_ff[b_letter]  & ~clr_b;
      hit_ie_ff    <= inc_vld_ff[b_evicted] & ~clr_b;
      hit_dl_ff    <= dec_vld_ff[b_letter]  & ~clr_b;
      hit_de_ff    <= dec_vld_ff[b_evicted] & ~clr_b;
   end

   // Merge RAM data with last cycle's writes
   always_comb begin
      if (fi_vld_ff && fi_addr_ff == c_letter_ff) begin
         inc_l = fi_data_ff;
      end else begin
         inc_l = hit_il_ff ? inc_l_rd : '0;
      end
      if (fi_vld_ff && fi_addr_ff == c_evicted_ff) begin
         inc_e = fi_data_ff;
      end else begin
         inc_e = hit_ie_ff ? inc_e_rd : '0;
      end
      if (fd_vld_ff && fd_addr_ff == c_letter_ff) begin
         dec_l = fd_data_ff;
      end else begin
         dec_l = hit_dl_ff ? dec_l_rd : '0;
      end
      if (fd_vld_ff && fd_addr_ff == c_evicted_ff) begin
         dec_e = fd_data_ff;
      end else begin
         dec_e = hit_de_ff ? dec_e_rd : '0;
      end
   end

   // Letter count in window is adds minus removes
   assign cnt_l = inc_l - dec_l;
   assign cnt_e = inc_e - dec_e;

   assign inc_wr_en   = c_ctl_ff.valid & c_ctl_ff.letter_ok & ~clr_b;
   assign dec_wr_en   = inc_wr_en & c_ctl_ff.evict;
   assign inc_wr_data = inc_l + CNT_W'(1);
   assign dec_wr_data = dec_e + CNT_W'(1);

   // Update the distinct total and raise the marker once per stream
   always_comb begin
      base_dist  = c_ctl_ff.start ? '0 : distinct_ff;
      base_found = c_ctl_ff.start ? 1'b0 : found_ff;
      dist_new   = base_dist;
      found_now  = 1'b0;
      if (c_ctl_ff.letter_ok) begin
         if (cnt_l == '0) begin
            dist_new = dist_new + CNT_W'(1);
         end
         if (c_ctl_ff.evict && c_evicted_ff != c_letter_ff && cnt_e == CNT_W'(1)) begin
            dist_new = dist_new - CNT_W'(1);
         end
         found_now = ~base_found & c_ctl_ff.full & (dist_new == c_len_ff);
      end
   end

   // Hold stream totals and valid bits
   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         distinct_ff <= '0;
         found_ff    <= 1'b0;
         inc_vld_ff  <= '0;
         dec_vld_ff  <= '0;
         fi_vld_ff   <= 1'b0;
         fd_vld_ff   <= 1'b0;
      end else begin
         if (c_ctl_ff.valid) begin
            distinct_ff <= dist_new;
            found_ff    <= base_found | found_now;
         end
         if (clr_b) begin
            inc_vld_ff <= '0;
            dec_vld_ff <= '0;
         end else begin
            if (inc_wr_en) begin
               inc_vld_ff[c_letter_ff] <= 1'b1;
            end
            if (dec_wr_en) begin
               dec_vld_ff[c_evicted_ff] <= 1'b1;
            end
         end
         fi_vld_ff <= inc_wr_en;
         fd_vld_ff <= dec_wr_en;
      end
   end

   always_ff @(posedge clock) begin
      fi_addr_ff <= c_letter_ff;
      fi_data_ff <= inc_wr_data;
      fd_addr_ff <= c_evicted_ff;
      fd_data_ff <= dec_wr_data;
   end

   assign res_valid     = c_ctl_ff.valid;
   assign res.found     = found_now;
   assign res.position  = c_pos_ff;
   assign res.distinct  = dist_new;

endmodule

// File: rtl/sliding_window_distinct_detector.sv
// Sliding window distinct detector: top level with result queue and flow control.
`timescale 1ns / 1ps

// Takes one lowercase letter per cycle while req_ready is high and returns one
// result beat per letter: the position in the stream, the number of different
// letters in the last window_length letters, and a marker on the first letter
// that completes a full window of all-different letters. Throughput is one
// letter per clock, back to back, while req_ready is high; a result reaches
// the output through the ring RAM read at the accepting edge, then the counter
// RAM read, then the write into the result queue. A four-entry result queue
// lets the input keep flowing while the output stalls; req_ready drops only
// when the queue plus the two beats in flight would overflow it. There is no
// clearing pass after reset: per-letter valid bits clear the counters at once,
// so the block takes letters from the first cycle after reset. A start flag on
// a letter, or a write to the window length register, begins a new stream;
// configure only while no beats are in flight.
module sliding_window_distinct_detector import swdd_pkg::*; #(
   parameter int MAX_WINDOW    = 14,
   parameter int ALPHABET_SIZE = 26
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [SYM_W-1:0] req_symbol,
   input  logic             req_start_of_stream,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_marker_found,
   output logic [POS_W-1:0] rsp_position,
   output logic [CNT_W-1:0] rsp_distinct_in_window
);

   localparam int LW = $clog2(ALPHABET_SIZE);

   swdd_ctl_type     b_ctl;
   logic [LW-1:0]    b_letter;
   logic [LW-1:0]    b_evicted;
   logic [LEN_W-1:0] b_len;
   logic [POS_W-1:0] b_position;
   logic             res_valid;
   swdd_result_type  res;
   logic             accept;

   swdd_result_type  q_mem_ff [QDEPTH];
   logic [QAW-1:0]   q_wr_ptr_ff, q_rd_ptr_ff;
   logic [QCW-1:0]   q_count_ff;
   logic [QCW-1:0]   occupancy;
   logic             push, pop;
   swdd_result_type  q_head;

   assign accept = req_valid & req_ready;

   swdd_window #(
      .MAX_WINDOW    (MAX_WINDOW),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_accept   (accept),
      .in_symbol   (req_symbol),
      .in_start    (req_start_of_stream),
      .b_ctl       (b_ctl),
      .b_letter    (b_letter),
      .b_evicted   (b_evicted),
      .b_len       (b_len),
      .b_position  (b_position)
   );

   swdd_tally #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_tally (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .b_ctl      (b_ctl),
      .b_letter   (b_letter),
      .b_evicted  (b_evicted),
      .b_len      (b_len),
      .b_position (b_position),
      .res_valid  (res_valid),
      .res        (res)
   );

   // Reserve queue room for every beat already in the pipeline
   assign occupancy = q_count_ff + QCW'(b_ctl.valid) + QCW'(res_valid);
   assign req_ready = (occupancy < QCW'(QDEPTH));

   assign push = res_valid;
   assign pop  = rsp_valid & rsp_ready;

   // Result queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
         q_count_ff  <= '0;
      end else begin
         if (push) begin
            q_wr_ptr_ff <= q_wr_ptr_ff + QAW'(1);
         end
         if (pop) begin
            q_rd_ptr_ff <= q_rd_ptr_ff + QAW'(1);
         end
         if (push && !pop) begin
            q_count_ff <= q_count_ff + QCW'(1);
         end else if (pop && !push) begin
            q_count_ff <= q_count_ff - QCW'(1);
         end
      end
   end

   // Store result beats
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[q_wr_ptr_ff] <= res;
      end
   end

   assign q_head                 = q_mem_ff[q_rd_ptr_ff];
   assign rsp_valid              = (q_count_ff != '0);
   assign rsp_marker_found       = q_head.found;
   assign rsp_position           = q_head.position;
   assign rsp_distinct_in_window = q_head.distinct;

`ifndef SYNTH
   // Queue never takes a beat when full
   assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && q_count_ff == QCW'(QDEPTH)))
      else $error("result queue overflow");

   // Queued plus in-flight beats stay within the queue depth
   assert property (@(posedge clock) disable iff (reset)
      occupancy <= QCW'(QDEPTH))
      else $error("in-flight beats exceed queue room");

   // A marker can only come after at least one letter
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_marker_found) |-> (rsp_position != '0))
      else $error("marker with zero position");

   // Letters in the window imply letters seen in the stream
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_distinct_in_window != '0) |-> (rsp_position != '0))
      else $error("distinct count with zero position");
`endif

endmodule

// File: sim/sliding_window_distinct_detector_tb.sv
// Self-checking testbench for the sliding window distinct detector.
`timescale 1ns / 1ps

// Tracks the detector's window and letter counts and holds the results it should return.
class window_scoreboard;
   localparam int WIN_MAX = 14;
   localparam int LETTERS = 26;

   logic [swdd_pkg::LEN_W-1:0] len_reg;
   int unsigned                ring [WIN_MAX];
   int unsigned                oldest;
   int unsigned                fill;
   int unsigned                counts [LETTERS];
   int unsigned                distinct;
   logic [swdd_pkg::POS_W-1:0] seen;
   bit                         marked;
   swdd_pkg::swdd_result_type  pending_results [$];
   int                         errors;

   function new();
      len_reg = swdd_pkg::LEN_RESET;
      errors  = 0;
      restart();
   endfunction

   // Clear the window, counts, position and marker
   function void restart();
      foreach (counts[i]) counts[i] = 0;
      oldest   = 0;
      fill     = 0;
      distinct = 0;
      seen     = '0;
      marked   = 1'b0;
   endfunction

   // A register write also begins a new stream
   function void set_length(logic [swdd_pkg::LEN_W-1:0] v);
      len_reg = v;
      restart();
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   // Advance the window by one accepted beat and queue the result it produces
   function void take_letter(logic [swdd_pkg::SYM_W-1:0] sym, logic start);
      int unsigned               span;
      int unsigned               idx;
      int unsigned               slot;
      swdd_pkg::swdd_result_type r;
      span = (len_reg == 0) ? 1 : ((len_reg > WIN_MAX) ? WIN_MAX : 32'(len_reg));
      if (start)
         restart();
      r.found = 1'b0;
      if (sym >= swdd_pkg::FIRST_LETTER && sym < swdd_pkg::FIRST_LETTER + LETTERS) begin
         idx = 32'(sym - swdd_pkg::FIRST_LETTER);
         if (fill < span) begin
            ring[fill] = idx;
            fill++;
         end else begin
            // evict the oldest letter from the counts
            slot = (oldest < WIN_MAX) ? oldest : 0;
            if (counts[ring[slot]] != 0) begin
               counts[ring[slot]]--;
               if (counts[ring[slot]] == 0 && distinct > 0)
                  distinct--;
            end
            ring[slot] = idx;
            slot++;
            if (slot >= span)
               slot = 0;
            oldest = slot;
         end
         counts[idx]++;
         if (counts[idx] == 1)
            distinct++;
         if (seen != '1)
            seen++;
         if (!marked && fill == span && distinct == span) begin
            r.found = 1'b1;
            marked  = 1'b1;
         end
      end
      r.position = seen;
      r.distinct = distinct[swdd_pkg::CNT_W-1:0];
      pending_results.push_back(r);
   endfunction

   // Compare one result beat against the oldest expectation
   function void match_result(logic found, logic [swdd_pkg::POS_W-1:0] position,
                              logic [swdd_pkg::CNT_W-1:0] cnt);
      swdd_pkg::swdd_result_type e;
      if (pending_results.size() == 0) begin
         $error("result beat with nothing expected: found %0d position %0d distinct %0d",
                found, position, cnt);
         errors++;
         return;
      end
      e = pending_results.pop_front();
      if (found !== e.found) begin
         $error("marker_found: expected %0d, got %0d", e.found, found);
         errors++;
      end
      if (position !== e.position) begin
         $error("position: expected %0d, got %0d", e.position, position);
         errors++;
      end
      if (cnt !== e.distinct) begin
         $error("distinct_in_window: expected %0d, got %0d", e.distinct, cnt);
         errors++;
      end
   endfunction
endclass

module sliding_window_distinct_detector_tb;
   import swdd_pkg::*;

   localparam int WIN_MAX      = 14;
   localparam int LETTERS      = 26;
   localparam int PIPE_SETTLE  = 6;
   localparam int STALL_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 470;
   localparam int CFG_INTERVAL = 110;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [LEN_W-1:0] csr_wr_data = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [SYM_W-1:0] req_symbol = FIRST_LETTER;
   logic             req_start_of_stream = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_marker_found;
   logic [POS_W-1:0] rsp_position;
   logic [CNT_W-1:0] rsp_distinct_in_window;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles  = 0;

   window_scoreboard board = new();

   sliding_window_distinct_detector #(
      .MAX_WINDOW    (WIN_MAX),
      .ALPHABET_SIZE (LETTERS)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_symbol             (req_symbol),
      .req_start_of_stream    (req_start_of_stream),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_marker_found       (rsp_marker_found),
      .rsp_position           (rsp_position),
      .rsp_distinct_in_window (rsp_distinct_in_window)
   );

   always #6 clock = ~clock;

   // Check result beats and stall the result side at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.match_result(rsp_marker_found, rsp_position, rsp_distinct_in_window);
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // End the run when no beat moves on either side for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one letter beat, idling first at random, and hold it until taken
   task automatic send_letter(input logic [SYM_W-1:0] sym, input logic start);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_symbol          <= sym;
      req_start_of_stream <= start;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      board.take_letter(sym, start);
   endtask

   // Hold off the input until every expected result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   task automatic write_window_length(input logic [LEN_W-1:0] v);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_length(v);
   endtask

   // One stream: either a rotating run of letters that tends to hit the marker,
   // or letters drawn from a random subset that keeps repeating; some noise mixed in
   task automatic run_stream(input int n);
      int               i;
      int               k;
      int               base;
      int               x;
      bit               rotate;
      logic [SYM_W-1:0] sym;
      logic             start;
      rotate = 1'($urandom_range(0, 1));
      k      = $urandom_range(1, LETTERS);
      base   = $urandom_range(0, LETTERS - 1);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 6) begin
            sym = SYM_W'($urandom_range(0, 127));
         end else begin
            if (rotate && $urandom_range(0, 99) >= 8)
               x = (base + i) % LETTERS;
            else
               x = (base + $urandom_range(0, k - 1)) % LETTERS;
            sym = FIRST_LETTER + SYM_W'(x);
         end
         start = (i == 0) || ($urandom_range(0, 99) < 3);
         send_letter(sym, start);
      end
   endtask

   initial begin
      int phase;
      int count;
      int next_cfg;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: first window all distinct, sliding past the marker, letter extremes
      send_letter(SYM_W'("a"), 1'b0);
      send_letter(SYM_W'("b"), 1'b0);
      send_letter(SYM_W'("c"), 1'b0);
      send_letter(SYM_W'("d"), 1'b0);
      send_letter(SYM_W'("e"), 1'b0);
      send_letter(7'd0, 1'b0);
      send_letter(7'd127, 1'b0);
      send_letter(SYM_W'("z"), 1'b0);
      send_letter(7'd96, 1'b0);
      send_letter(7'd123, 1'b0);
      // start flag on a non-letter still clears the stream
      send_letter(7'd127, 1'b1);
      send_letter(SYM_W'("q"), 1'b1);
      send_letter(SYM_W'("a"), 1'b0);
      send_letter(SYM_W'("a"), 1'b0);
      // zero length acts as one
      write_window_length(4'd0);
      send_letter(SYM_W'("c"), 1'b1);
      send_letter(SYM_W'("c"), 1'b0);
      // above the maximum acts as the maximum
      write_window_length(4'd15);
      send_letter(SYM_W'("m"), 1'b0);
      send_letter(SYM_W'("n"), 1'b0);

      // Random: receiver-heavy idling, then sender-heavy, then none
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 35 : ((phase == 1) ? 77 : 0);
         recv_idle_pct = (phase == 0) ? 77 : ((phase == 1) ? 35 : 0);
         write_window_length((phase == 0) ? 4'd14 : ((phase == 1) ? 4'd1 : 4'd15));
         count    = 0;
         next_cfg = CFG_INTERVAL;
         while (count < PHASE_ITEMS) begin
            if (count >= next_cfg) begin
               write_window_length(LEN_W'($urandom_range(0, 15)));
               next_cfg += CFG_INTERVAL;
            end else if ($urandom_range(0, 99) < 4) begin
               drain_results();
            end
            k_stream: begin
               int n;
               n = $urandom_range(1, 40);
               run_stream(n);
               count += n;
            end
         end
      end

      drain_results();
      if (board.errors == 0 && board.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
